// ===== hdl/lmssd_pkg.sv =====
// Shared types and constants for the scrolling LED matrix shift driver.
// No dependencies; compiled first.
package lmssd_pkg;

    // Command codes carried in the cmd field of an input beat
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MESSAGE_LENGTH  = 2'd0,
        REG_FRAMES_PER_STEP = 2'd1,
        REG_DWELL_TICKS     = 2'd2
    } cfg_reg_t;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned ROW_COUNT  = 8;

    localparam logic [7:0]  FRAMES_PER_STEP_RST = 8'd10;
    localparam logic [15:0] DWELL_TICKS_RST     = 16'd2500;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] address;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       serial_data;
        logic       shift_clock;
        logic       store_clock;
        logic       busy_res;
        logic [2:0] row_index;
        logic [7:0] scroll_offset;
    } out_item_t;

endpackage

// ===== hdl/lmssd_in_if.sv =====
// Command channel interface: valid/ready handshake with one input beat.
// Depends on lmssd_pkg.
interface lmssd_in_if import lmssd_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/lmssd_out_if.sv =====
// Result channel interface: valid/ready handshake with one result beat.
// Depends on lmssd_pkg.
interface lmssd_out_if import lmssd_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hdl/led_matrix_scroll_shift_driver_top.sv =====
// Scrolling LED matrix driver top level: message store, pin sequencer, result skid.
// Depends on lmssd_pkg, lmssd_in_if and lmssd_out_if.

// The block takes one command beat per clock while its skid entry is free and returns
// one result beat per command, registered into the output register, or into the skid
// entry while earlier results wait unread. The message store is a single-port-write,
// registered-read memory; the byte for the current row (offset + row, wrapping at
// MSG_DEPTH) is prefetched into a read register every cycle, with store writes
// forwarded into it, so a tick that loads a row word need not wait for the read. The
// result side has an output register plus one skid entry, so commands keep flowing
// while one result waits; the command channel only stalls when both hold unread
// results. No clearing pass is run after reset: store entries are valid once written.
module led_matrix_scroll_shift_driver_top
    import lmssd_pkg::*;
#(
    parameter int MSG_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lmssd_in_if.sink              cmd_ch,
    lmssd_out_if.source           res_ch,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MSG_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(MSG_DEPTH - 1);
    localparam logic [8:0] DEPTH_LIM = 9'(MSG_DEPTH);

    typedef enum logic [1:0] {
        PH_BITS,
        PH_LATCH_HI,
        PH_LATCH_LO,
        PH_DWELL
    } phase_t;

    // Configuration registers
    logic [7:0]  msg_len_reg;
    logic [7:0]  fps_reg;
    logic [15:0] dwell_ticks_reg;

    // Sequencer state
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [1:0]  sub_reg, sub_next;
    logic [15:0] dwell_reg, dwell_next;
    logic [2:0]  row_reg, row_next;
    logic [7:0]  frame_reg, frame_next;
    logic [7:0]  offset_reg, offset_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [15:0] word_reg, word_next;
    logic        running_reg, running_next;
    logic        pin_data_reg, pin_data_next;
    logic        pin_shift_reg, pin_shift_next;
    logic        pin_store_reg, pin_store_next;

    // Message store and prefetch register
    logic [7:0]  mem [MSG_DEPTH];
    logic [7:0]  rd_data_reg;

    // Result buffering
    logic        out_valid_reg;
    logic        skid_valid_reg;
    out_item_t   out_reg;
    out_item_t   skid_reg;
    out_item_t   result;

    logic        accept;
    logic        out_free;
    logic        row_end;
    logic        wr_en;
    logic [AW-1:0] wr_idx;
    logic [15:0] dwell_inc;
    logic [7:0]  frame_inc;
    logic [15:0] load_word;
    logic [15:0] cur_word;

    assign accept   = cmd_ch.valid && cmd_ch.ready;
    assign out_free = !out_valid_reg || res_ch.ready;

    assign cmd_ch.ready = !skid_valid_reg;
    assign res_ch.valid = out_valid_reg;
    assign res_ch.item  = out_reg;

    assign wr_en  = accept && (cmd_ch.item.cmd == CMD_WRITE)
                    && ({1'b0, cmd_ch.item.address} < DEPTH_LIM);
    assign wr_idx = cmd_ch.item.address[AW-1:0];

    assign dwell_inc = dwell_reg + 16'd1;
    assign frame_inc = frame_reg + 8'd1;
    assign load_word = {rd_data_reg, 8'(1) << row_reg};
    assign cur_word  = (bit_reg == 4'd0) ? load_word : word_reg;

    // Advance the pin sequencer for one command
    always_comb
    begin
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        sub_next       = sub_reg;
        dwell_next     = dwell_reg;
        row_next       = row_reg;
        frame_next     = frame_reg;
        offset_next    = offset_reg;
        base_next      = base_reg;
        ptr_next       = ptr_reg;
        word_next      = word_reg;
        running_next   = running_reg;
        pin_data_next  = pin_data_reg;
        pin_shift_next = pin_shift_reg;
        pin_store_next = pin_store_reg;
        row_end        = 1'b0;

        if (accept)
        begin
            case (cmd_ch.item.cmd)
                CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        case (phase_reg)
                            PH_BITS:
                            begin
                                case (sub_reg)
                                    2'd0:
                                    begin
                                        word_next      = cur_word;
                                        pin_data_next  = cur_word[~bit_reg];
                                        pin_shift_next = 1'b0;
                                        sub_next       = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        pin_shift_next = 1'b1;
                                        sub_next       = 2'd2;
                                    end
                                    default:
                                    begin
                                        pin_shift_next = 1'b0;
                                        sub_next       = 2'd0;
                                        bit_next       = bit_reg + 4'd1;
                                        if (bit_reg == 4'd15)
                                        begin
                                            phase_next = PH_LATCH_HI;
                                        end
                                    end
                                endcase
                            end
                            PH_LATCH_HI:
                            begin
                                pin_store_next = 1'b1;
                                phase_next     = PH_LATCH_LO;
                            end
                            PH_LATCH_LO:
                            begin
                                pin_store_next = 1'b0;
                                if (dwell_ticks_reg == 16'd0)
                                begin
                                    row_end = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_DWELL;
                                    dwell_next = 16'd0;
                                end
                            end
                            default:
                            begin
                                dwell_next = dwell_inc;
                                if (dwell_inc >= dwell_ticks_reg)
                                begin
                                    row_end = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                CMD_START:
                begin
                    offset_next  = 8'd0;
                    frame_next   = 8'd0;
                    row_next     = 3'd0;
                    phase_next   = PH_BITS;
                    bit_next     = 4'd0;
                    sub_next     = 2'd0;
                    dwell_next   = 16'd0;
                    base_next    = '0;
                    ptr_next     = '0;
                    running_next = (msg_len_reg > 8'(ROW_COUNT));
                end
                default:
                begin
                    // store writes and the unused code leave the sequencer alone
                end
            endcase
        end

        // Close the row; at the last row step the frame, and the offset once the frame count wraps
        if (row_end)
        begin
            phase_next = PH_BITS;
            bit_next   = 4'd0;
            sub_next   = 2'd0;
            dwell_next = 16'd0;
            row_next   = row_reg + 3'd1;
            if (row_reg == 3'(ROW_COUNT - 1))
            begin
                if (frame_inc == fps_reg)
                begin
                    frame_next  = 8'd0;
                    offset_next = offset_reg + 8'd1;
                    base_next   = (base_reg == LAST_IDX) ? '0 : base_reg + AW'(1);
                end
                else
                begin
                    frame_next = frame_inc;
                end
                ptr_next = base_next;
                if ({1'b0, offset_next} + 9'd8 >= {1'b0, msg_len_reg})
                begin
                    running_next = 1'b0;
                end
            end
            else
            begin
                ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + AW'(1);
            end
        end

        result.serial_data   = pin_data_next;
        result.shift_clock   = pin_shift_next;
        result.store_clock   = pin_store_next;
        result.busy_res      = running_next;
        result.row_index     = row_next;
        result.scroll_offset = offset_next;
    end

    // Hold configuration and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_len_reg     <= 8'd0;
            fps_reg         <= FRAMES_PER_STEP_RST;
            dwell_ticks_reg <= DWELL_TICKS_RST;
            phase_reg       <= PH_BITS;
            bit_reg         <= 4'd0;
            sub_reg         <= 2'd0;
            dwell_reg       <= 16'd0;
            row_reg         <= 3'd0;
            frame_reg       <= 8'd0;
            offset_reg      <= 8'd0;
            base_reg        <= '0;
            ptr_reg         <= '0;
            word_reg        <= 16'd0;
            running_reg     <= 1'b0;
            pin_data_reg    <= 1'b0;
            pin_shift_reg   <= 1'b0;
            pin_store_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MESSAGE_LENGTH:  msg_len_reg     <= cfg_data[7:0];
                    REG_FRAMES_PER_STEP: fps_reg         <= cfg_data[7:0];
                    REG_DWELL_TICKS:     dwell_ticks_reg <= cfg_data;
                    default:
                    begin
                        // no register at this index
                    end
                endcase
            end

            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            sub_reg       <= sub_next;
            dwell_reg     <= dwell_next;
            row_reg       <= row_next;
            frame_reg     <= frame_next;
            offset_reg    <= offset_next;
            base_reg      <= base_next;
            ptr_reg       <= ptr_next;
            word_reg      <= word_next;
            running_reg   <= running_next;
            pin_data_reg  <= pin_data_next;
            pin_shift_reg <= pin_shift_next;
            pin_store_reg <= pin_store_next;

            // Output register drains first; skid catches a beat while it is blocked
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    // Write the store; prefetch the byte at the next row pointer with write forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= cmd_ch.item.data;
        end
        if (wr_en && (wr_idx == ptr_next))
        begin
            rd_data_reg <= cmd_ch.item.data;
        end
        else
        begin
            rd_data_reg <= mem[ptr_next];
        end
    end

endmodule

// ===== hdl/lmssd_checker.sv =====
// Port-level checks for the scrolling LED matrix driver, bound to its top level.
// Depends on lmssd_pkg and led_matrix_scroll_shift_driver_top.
module lmssd_prop_checker
    import lmssd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input out_item_t res_item
);

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result beat dropped or changed while stalled");

    // Have a result beat valid the cycle after a command is taken
    a_cmd_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> res_valid)
        else $error("accepted command gave no result beat");

    // Stall commands only while results are waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid)
        else $error("command channel stalled with no result pending");

endmodule

bind led_matrix_scroll_shift_driver_top lmssd_prop_checker u_lmssd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_ch.valid),
    .cmd_ready (cmd_ch.ready),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .res_item  (res_ch.item)
);
